@@ hdl/vrt_pkg.sv @@
// ----------------------------------------------------------------------------
// vrt_pkg
// Types and constants shared by the voxel ray traversal controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int ORG_W  = 26;  // origin, signed Q10.16
  localparam int DIR_W  = 18;  // direction, signed Q2.16
  localparam int FRAC_W = 16;
  localparam int DIST_W = 17;  // distance to first boundary, Q.16, up to 1.0
  localparam int MAG_W  = 18;  // |direction|, up to 2.0
  localparam int DIV_W  = 33;  // dividend and quotient, up to 2^32
  localparam int T_W    = 48;  // ray parameter, unsigned Q32.16
  localparam int CELL_W = 12;  // signed voxel coordinate during the walk
  localparam int DIM_W  = 11;  // clamped grid size
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 10;
  localparam int JOB_W  = 3;
  localparam int NUM_DIV_JOBS = 6;  // tmax and tdelta for each of three axes

  localparam logic [T_W-1:0] T_INF = {T_W{1'b1}};

  localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GRID_DEPTH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_DIST    = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [2:0] FACE_POS_Y = 3'd0;
  localparam logic [2:0] FACE_NEG_Y = 3'd1;
  localparam logic [2:0] FACE_POS_Z = 3'd2;
  localparam logic [2:0] FACE_NEG_Z = 3'd3;
  localparam logic [2:0] FACE_POS_X = 3'd4;
  localparam logic [2:0] FACE_NEG_X = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WR,
    ST_DIV_SETUP,
    ST_DIV_WAIT,
    ST_WALK_CHK,
    ST_WALK_BIT,
    ST_DONE
  } vrt_state_t;

  typedef struct packed {
    logic             clr_en;
    logic             load_in;
    logic             wr_rd;
    logic             wr_wr;
    logic [JOB_W-1:0] job;
    logic             div_start;
    logic             div_store;
    logic             div_inf;
    logic             walk_rd;
    logic             walk_step;
    logic             mark_hit;
    logic             out_load;
  } vrt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wr_in_range;
    logic dir_zero;
    logic div_done;
    logic stop_walk;
    logic occ_bit;
    logic out_busy;
  } vrt_status_t;

endpackage

@@ hdl/voxel_ray_traversal_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_ray_traversal_unit
// Voxel occupancy grid with 3D DDA ray casting.
// ----------------------------------------------------------------------------
// After reset the unit clears all GRID_Y*GRID_Z rows (16384 at the defaults)
// of its occupancy memory, one row of GRID_X voxels per cycle, with in_tready
// low. A write request is a read-modify-write of one memory row. A cast
// request first forms tmax and tdelta for each moving axis on the shared
// one-bit-per-cycle divider, then walks the grid one voxel at a time
// (memory read, then test and step).
// One request is worked on at a time; a finished result waits in the output
// register while the next request is accepted.
module voxel_ray_traversal_unit #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [vrt_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [vrt_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // voxel_x, voxel_y, voxel_z, occupied, origin_x, origin_y, origin_z,
  // dir_x, dir_y, dir_z
  input  logic [159:0]               in_tdata,
  input  logic                       in_tuser,   // command
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // hit_x, hit_y, hit_z, entry_face
  output logic                       out_tuser   // hit
);
  import vrt_pkg::*;

  vrt_cmd_t    cmd;
  vrt_status_t status;

  vrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vrt_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ hdl/vrt_divider.sv @@
// ----------------------------------------------------------------------------
// vrt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrt_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [vrt_pkg::DIV_W-1:0] dividend,
  input  logic [vrt_pkg::MAG_W-1:0] divisor,
  output logic                     done,
  output logic [vrt_pkg::DIV_W-1:0] quotient
);
  import vrt_pkg::*;

  localparam int REM_W = MAG_W + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, divisor} : trial;
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/vrt_datapath.sv @@
// ----------------------------------------------------------------------------
// vrt_datapath
// Occupancy memory, configuration registers, DDA setup and stepping,
// result register.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vrt_pkg::vrt_cmd_t          cmd,
  output vrt_pkg::vrt_status_t       status,
  input  logic                       cfg_we,
  input  logic [vrt_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [vrt_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [159:0]               in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  output logic                       out_tuser
);
  import vrt_pkg::*;

  localparam int ROWS = GRID_Y * GRID_Z;
  localparam int AW   = $clog2(ROWS);
  localparam int XW   = $clog2(GRID_X);

  // occupancy memory: one row of GRID_X bits per (y, z)
  logic [GRID_X-1:0] mem [ROWS];
  logic [GRID_X-1:0] rd_data_r;
  logic [GRID_X-1:0] wr_row;

  logic [8:0] grid_width_r, grid_height_r;
  logic [6:0] grid_depth_r;
  logic [9:0] max_dist_r;

  logic [AW-1:0] clr_cnt_r;
  logic [7:0]    vx_r, vz_r;
  logic [5:0]    vy_r;
  logic          occ_r;

  logic signed [DIR_W-1:0]  dir_r  [3];
  logic        [FRAC_W-1:0] frac_r [3];
  logic        [T_W-1:0]    tm_r   [3];
  logic        [T_W-1:0]    td_r   [3];
  logic signed [CELL_W-1:0] cx_r, cy_r, cz_r;
  logic        [T_W-1:0]    t_r;
  logic        [2:0]        face_r;
  logic                     res_hit_r;

  logic        out_valid_r;
  logic        out_hit_r;
  logic [7:0]  out_x_r, out_z_r;
  logic [5:0]  out_y_r;
  logic [2:0]  out_face_r;

  // divider hookup
  logic [1:0]              axis;
  logic signed [DIR_W-1:0] dsel;
  logic [MAG_W-1:0]        mag;
  logic [DIST_W-1:0]       bnd_len;
  logic [DIV_W-1:0]        dividend;
  logic                    div_done;
  logic [DIV_W-1:0]        quotient;

  always_comb begin
    axis = cmd.job[2:1];
    dsel = dir_r[axis];
    mag  = dsel[DIR_W-1] ? MAG_W'(-dsel) : MAG_W'(dsel);
    bnd_len = dsel[DIR_W-1] ? DIST_W'(frac_r[axis])
                            : DIST_W'(1 << FRAC_W) - DIST_W'(frac_r[axis]);
    dividend = cmd.job[0] ? DIV_W'(64'd1 << 32) : {bnd_len, {FRAC_W{1'b0}}};
  end

  vrt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (mag),
    .done     (div_done),
    .quotient (quotient)
  );

  // addresses
  logic [AW-1:0]   wr_addr, walk_addr, rd_addr;
  logic [DIM_W-1:0] wx, wy, wz;
  logic            oob, t_over;

  always_comb begin
    wr_addr   = AW'(vy_r) * AW'(GRID_Z) + AW'(vz_r);
    walk_addr = AW'(cy_r) * AW'(GRID_Z) + AW'(cz_r);
    rd_addr   = cmd.wr_rd ? wr_addr : walk_addr;
    wx = (DIM_W'(grid_width_r)  > DIM_W'(GRID_X)) ? DIM_W'(GRID_X) : DIM_W'(grid_width_r);
    wy = (DIM_W'(grid_depth_r)  > DIM_W'(GRID_Y)) ? DIM_W'(GRID_Y) : DIM_W'(grid_depth_r);
    wz = (DIM_W'(grid_height_r) > DIM_W'(GRID_Z)) ? DIM_W'(GRID_Z) : DIM_W'(grid_height_r);
    oob = cx_r[CELL_W-1] || cy_r[CELL_W-1] || cz_r[CELL_W-1] ||
          (unsigned'(cx_r) >= CELL_W'(wx)) ||
          (unsigned'(cy_r) >= CELL_W'(wy)) ||
          (unsigned'(cz_r) >= CELL_W'(wz));
    t_over = t_r > T_W'({max_dist_r, {FRAC_W{1'b0}}});
  end

  // merge the written voxel into the row read the cycle before
  always_comb begin
    wr_row = rd_data_r;
    wr_row[XW'(vx_r)] = occ_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr_wr) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.wr_rd || cmd.walk_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 9'd256;
      grid_depth_r  <= 7'd64;
      grid_height_r <= 9'd256;
      max_dist_r    <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[8:0];
        REG_GRID_DEPTH:  grid_depth_r  <= cfg_wdata[6:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[8:0];
        REG_MAX_DIST:    max_dist_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stepping: x only when strictly smallest, then y when below z, else z
  logic          sel_x, sel_y;
  logic [T_W:0]  sum_x, sum_y, sum_z;

  always_comb begin
    sel_x = (tm_r[0] < tm_r[1]) && (tm_r[0] < tm_r[2]);
    sel_y = !(tm_r[0] < tm_r[1]) && (tm_r[1] < tm_r[2]);
    sum_x = {1'b0, tm_r[0]} + {1'b0, td_r[0]};
    sum_y = {1'b0, tm_r[1]} + {1'b0, td_r[1]};
    sum_z = {1'b0, tm_r[2]} + {1'b0, td_r[2]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vx_r      <= in_tdata[7:0];
      vy_r      <= in_tdata[13:8];
      vz_r      <= in_tdata[21:14];
      occ_r     <= in_tdata[22];
      frac_r[0] <= in_tdata[38:23];
      frac_r[1] <= in_tdata[64:49];
      frac_r[2] <= in_tdata[90:75];
      cx_r      <= CELL_W'($signed(in_tdata[48:39]));
      cy_r      <= CELL_W'($signed(in_tdata[74:65]));
      cz_r      <= CELL_W'($signed(in_tdata[100:91]));
      dir_r[0]  <= $signed(in_tdata[118:101]);
      dir_r[1]  <= $signed(in_tdata[136:119]);
      dir_r[2]  <= $signed(in_tdata[154:137]);
      t_r       <= '0;
      face_r    <= FACE_POS_Y;
      res_hit_r <= 1'b0;
    end
    if (cmd.div_store || cmd.div_inf) begin
      if (cmd.job[0]) begin
        td_r[axis] <= cmd.div_inf ? T_INF : T_W'(quotient);
      end else begin
        tm_r[axis] <= cmd.div_inf ? T_INF : T_W'(quotient);
      end
    end
    if (cmd.mark_hit) begin
      res_hit_r <= 1'b1;
    end
    if (cmd.walk_step) begin
      if (sel_x) begin
        cx_r    <= dir_r[0][DIR_W-1] ? cx_r - 1'b1 : cx_r + 1'b1;
        t_r     <= tm_r[0];
        tm_r[0] <= sum_x[T_W] ? T_INF : sum_x[T_W-1:0];
        face_r  <= dir_r[0][DIR_W-1] ? FACE_NEG_X : FACE_POS_X;
      end else if (sel_y) begin
        cy_r    <= dir_r[1][DIR_W-1] ? cy_r - 1'b1 : cy_r + 1'b1;
        t_r     <= tm_r[1];
        tm_r[1] <= sum_y[T_W] ? T_INF : sum_y[T_W-1:0];
        face_r  <= dir_r[1][DIR_W-1] ? FACE_NEG_Y : FACE_POS_Y;
      end else begin
        // zero z direction only lands here with every t infinite: hold z
        if (dir_r[2] != '0) begin
          cz_r <= dir_r[2][DIR_W-1] ? cz_r - 1'b1 : cz_r + 1'b1;
        end
        t_r     <= tm_r[2];
        tm_r[2] <= sum_z[T_W] ? T_INF : sum_z[T_W-1:0];
        face_r  <= (dir_r[2] > 0) ? FACE_POS_Z : FACE_NEG_Z;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r  <= res_hit_r;
      out_x_r    <= res_hit_r ? 8'(cx_r) : 8'd0;
      out_y_r    <= res_hit_r ? 6'(cy_r) : 6'd0;
      out_z_r    <= res_hit_r ? 8'(cz_r) : 8'd0;
      out_face_r <= res_hit_r ? face_r : 3'd0;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    status.clr_last    = clr_cnt_r == AW'(ROWS - 1);
    status.wr_in_range = (DIM_W'(vx_r) < DIM_W'(GRID_X)) &&
                         (DIM_W'(vy_r) < DIM_W'(GRID_Y)) &&
                         (DIM_W'(vz_r) < DIM_W'(GRID_Z));
    status.dir_zero    = dsel == '0;
    status.div_done    = div_done;
    status.stop_walk   = t_over || oob;
    status.occ_bit     = rd_data_r[XW'(cx_r)];
    status.out_busy    = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {7'd0, out_face_r, out_z_r, out_y_r, out_x_r};

endmodule

@@ hdl/vrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: memory clear after reset, voxel writes, tmax and tdelta setup and
// the voxel walk.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tuser,
  output logic                 in_tready,
  input  vrt_pkg::vrt_status_t status,
  output vrt_pkg::vrt_cmd_t    cmd
);
  import vrt_pkg::*;

  vrt_state_t        state_r, state_nxt;
  logic [JOB_W-1:0]  job_r, job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      job_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cmd       = '0;
    cmd.job   = job_r;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          job_nxt     = '0;
          state_nxt   = (in_tuser == CMD_CAST) ? ST_DIV_SETUP : ST_WR_RD;
        end
      end
      ST_WR_RD: begin
        if (status.wr_in_range) begin
          cmd.wr_rd = 1'b1;
          state_nxt = ST_WR_WR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WR_WR: begin
        cmd.wr_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DIV_SETUP: begin
        if (status.dir_zero) begin
          cmd.div_inf = 1'b1;
          job_nxt     = job_r + 1'b1;
          if (job_r == JOB_W'(NUM_DIV_JOBS - 1)) begin
            state_nxt = ST_WALK_CHK;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          job_nxt       = job_r + 1'b1;
          state_nxt = (job_r == JOB_W'(NUM_DIV_JOBS - 1)) ? ST_WALK_CHK : ST_DIV_SETUP;
        end
      end
      ST_WALK_CHK: begin
        if (status.stop_walk) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = ST_WALK_BIT;
        end
      end
      ST_WALK_BIT: begin
        if (status.occ_bit) begin
          cmd.mark_hit = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = ST_WALK_CHK;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ bench/tb_voxel_ray_traversal_unit.sv @@
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal_unit
// Self-checking bench for the voxel ray traversal unit. A scoreboard keeps
// its own occupancy grid and register copies, predicts each cast by 3D DDA
// stepping in Q32.16, and checks every result request in order.
// ----------------------------------------------------------------------------

typedef struct {
  bit       hit;
  bit [7:0] vx;
  bit [5:0] vy;
  bit [7:0] vz;
  bit [2:0] face;
} hit_report_t;

class ray_scoreboard;
  localparam longint TINF = 64'hFFFF_FFFF_FFFF;
  bit             occ[int];
  int unsigned    width, depth, height, reach;
  hit_report_t    pending[$];
  int             errors;

  function new();
    width = 256; depth = 64; height = 256; reach = 100; errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [9:0] val);
    case (idx)
      vrt_pkg::REG_GRID_WIDTH:  width  = 32'(val[8:0]);
      vrt_pkg::REG_GRID_DEPTH:  depth  = 32'(val[6:0]);
      vrt_pkg::REG_GRID_HEIGHT: height = 32'(val[8:0]);
      vrt_pkg::REG_MAX_DIST:    reach  = 32'(val);
      default: ;
    endcase
  endfunction

  function bit occupied_at(longint x, longint y, longint z);
    int k;
    k = int'({y[5:0], z[7:0], x[7:0]});
    return occ.exists(k) ? occ[k] : 1'b0;
  endfunction

  // first boundary and spacing along one axis
  function void axis_plan(longint o, longint d, longint c,
                          output int s, output longint tm, output longint td);
    longint mag, gap;
    if (d == 0) begin
      s = 0; tm = TINF; td = TINF;
      return;
    end
    if (d > 0) begin
      s = 1; mag = d; gap = (c + 1) * 65536 - o;
    end else begin
      s = -1; mag = -d; gap = o - c * 65536;
    end
    tm = (gap << 16) / mag;
    td = (64'd1 << 32) / mag;
  endfunction

  function longint sat(longint a, longint b);
    longint s;
    s = a + b;
    return (s > TINF) ? TINF : s;
  endfunction

  function void note_request(bit cmd, logic [159:0] d);
    hit_report_t r;
    longint ox, oy, oz, dx, dy, dz, x, y, z, tmx, tmy, tmz, tdx, tdy, tdz, t, tlim;
    longint wx, wy, wz;
    int sx, sy, sz;
    bit [2:0] face;
    if (cmd == vrt_pkg::CMD_WRITE) begin
      occ[int'({d[13:8], d[21:14], d[7:0]})] = d[22];
      return;
    end
    ox = longint'(signed'(d[48:23]));
    oy = longint'(signed'(d[74:49]));
    oz = longint'(signed'(d[100:75]));
    dx = longint'(signed'(d[118:101]));
    dy = longint'(signed'(d[136:119]));
    dz = longint'(signed'(d[154:137]));
    x = ox >>> 16; y = oy >>> 16; z = oz >>> 16;
    axis_plan(ox, dx, x, sx, tmx, tdx);
    axis_plan(oy, dy, y, sy, tmy, tdy);
    axis_plan(oz, dz, z, sz, tmz, tdz);
    wx = (width > 256) ? 256 : width;
    wy = (depth > 64) ? 64 : depth;
    wz = (height > 256) ? 256 : height;
    tlim = longint'(reach) << 16;
    t = 0;
    face = vrt_pkg::FACE_POS_Y;
    r = '{0, 0, 0, 0, 0};
    while (t <= tlim) begin
      if (x < 0 || y < 0 || z < 0 || x >= wx || y >= wy || z >= wz) break;
      if (occupied_at(x, y, z)) begin
        r = '{1, x[7:0], y[5:0], z[7:0], face};
        break;
      end
      if (tmx < tmy && tmx < tmz) begin
        x += sx; t = tmx; tmx = sat(tmx, tdx);
        face = (sx > 0) ? vrt_pkg::FACE_POS_X : vrt_pkg::FACE_NEG_X;
      end else if (!(tmx < tmy) && tmy < tmz) begin
        y += sy; t = tmy; tmy = sat(tmy, tdy);
        face = (sy > 0) ? vrt_pkg::FACE_POS_Y : vrt_pkg::FACE_NEG_Y;
      end else begin
        z += sz; t = tmz; tmz = sat(tmz, tdz);
        face = (sz > 0) ? vrt_pkg::FACE_POS_Z : vrt_pkg::FACE_NEG_Z;
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(bit hit, logic [31:0] d);
    hit_report_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result hit=%0b data=%h", $time, hit, d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (hit !== e.hit || d[7:0] !== e.vx || d[13:8] !== e.vy || d[21:14] !== e.vz ||
        d[24:22] !== e.face) begin
      $display("%0t: mismatch expected hit=%0b x=%0d y=%0d z=%0d face=%0d",
               $time, e.hit, e.vx, e.vy, e.vz, e.face);
      $display("%0t:          actual   hit=%0b x=%0d y=%0d z=%0d face=%0d",
               $time, hit, d[7:0], d[13:8], d[21:14], d[24:22]);
      errors++;
    end
  endfunction
endclass

module tb_voxel_ray_traversal_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [9:0]   cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         out_tuser;

  ray_scoreboard sb = new();
  bit            calm = 1'b0;

  voxel_ray_traversal_unit DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 10);
  end

  task automatic send_req(bit cmd, logic [159:0] d);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, d);
    if (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic write_voxel(int x, int y, int z, bit o);
    logic [159:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d[7:0] = 8'(x); d[13:8] = 6'(y); d[21:14] = 8'(z); d[22] = o;
    send_req(vrt_pkg::CMD_WRITE, d);
  endtask

  task automatic cast_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    logic [159:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d[159:155] = '0;
    d[48:23] = 26'(ox); d[74:49] = 26'(oy); d[100:75] = 26'(oz);
    d[118:101] = 18'(dx); d[136:119] = 18'(dy); d[154:137] = 18'(dz);
    send_req(vrt_pkg::CMD_CAST, d);
  endtask

  // hold input until every result is back, then let the block go idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic set_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic int mid(int c);
    return c * 65536 + 32768;
  endfunction

  function automatic int rand_comp();
    if ($urandom_range(99) < 20) return 0;
    return int'($urandom_range(131072)) - 65536;
  endfunction

  task automatic random_item(int span);
    int c;
    c = (span > 24) ? 24 : ((span < 1) ? 1 : span);
    if ($urandom_range(99) < 45) begin
      if ($urandom_range(99) < 80)
        write_voxel($urandom_range(c - 1), $urandom_range((c > 64 ? 64 : c) - 1),
                    $urandom_range(c - 1), $urandom_range(99) < 60);
      else
        write_voxel($urandom_range(255), $urandom_range(63), $urandom_range(255),
                    $urandom_range(1));
    end else if ($urandom_range(99) < 8) begin
      cast_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      cast_ray((int'($urandom_range(c + 3)) - 2) * 65536 + $urandom_range(65535),
               (int'($urandom_range(c + 3)) - 2) * 65536 + $urandom_range(65535),
               (int'($urandom_range(c + 3)) - 2) * 65536 + $urandom_range(65535),
               rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    int unsigned w[8] = '{256, 16, 1, 511, 0, 40, 256, 0};
    int unsigned dp[8] = '{64, 16, 1, 127, 64, 8, 64, 0};
    int unsigned h[8] = '{256, 16, 1, 511, 256, 40, 256, 0};
    int unsigned md[8] = '{100, 1023, 0, 1023, 100, 30, 1023, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    write_voxel(3, 2, 1, 1'b1);
    cast_ray(mid(0), mid(2), mid(1), 65536, 0, 0);
    cast_ray(mid(10), mid(2), mid(1), -65536, 0, 0);
    cast_ray(mid(3), mid(10), mid(1), 0, -65536, 0);
    cast_ray(mid(3), mid(0), mid(1), 0, 65536, 0);
    cast_ray(mid(3), mid(2), mid(9), 0, 0, -65536);
    cast_ray(mid(3), mid(2), mid(0), 0, 0, 65536);
    cast_ray(mid(3), mid(2), mid(1), 1000, 2000, -3000);
    cast_ray(mid(7), mid(7), mid(7), 0, 0, 0);
    cast_ray(mid(0), mid(0), mid(1), 46341, 46341, 0);
    cast_ray(mid(0), mid(0), mid(0), 37837, 37837, 37837);
    cast_ray(-33554432, -33554432, -33554432, 65536, 65536, 65536);
    cast_ray(33554431, 33554431, 33554431, -131072, -131072, -131072);
    cast_ray(0, 0, 0, 131071, 131071, 131071);
    write_voxel(255, 63, 255, 1'b1);
    cast_ray(mid(200), mid(63), mid(255), 65536, 0, 0);
    cast_ray(mid(255), mid(0), mid(255), 0, 65536, 0);
    write_voxel(3, 2, 1, 1'b0);
    cast_ray(mid(0), mid(2), mid(1), 65536, 0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        w[7] = $urandom_range(511); dp[7] = $urandom_range(127);
        h[7] = $urandom_range(511); md[7] = $urandom_range(1023);
      end
      set_reg(vrt_pkg::REG_GRID_WIDTH, 10'(w[p]));
      set_reg(vrt_pkg::REG_GRID_DEPTH, 10'(dp[p]));
      set_reg(vrt_pkg::REG_GRID_HEIGHT, 10'(h[p]));
      set_reg(vrt_pkg::REG_MAX_DIST, 10'(md[p]));
      cfg_we <= 1'b0;
      calm = (p == 6);
      repeat (191) random_item((w[p] == 0) ? 24 : w[p]);
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
